FILE: hw/rtl/rws_pkg.sv
`default_nettype none

package rws_pkg;

   localparam int FIT_W      = 14;
   localparam int SLOT_W     = 6;
   localparam int WORD_W     = 32;
   localparam int FRAC_W     = 16;
   localparam int SUM_W      = 20;
   localparam int BITS_W     = 6;
   localparam int POPC_W     = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   localparam int POP_MAX_DEFAULT = 64;
   localparam int RAND_BITS       = 16;

   localparam logic [BITS_W-1:0] CHROM_MAX       = 6'd32;
   localparam logic [BITS_W-1:0] CHROM_BITS_RESET = 6'd8;
   localparam logic [POPC_W-1:0] POP_COUNT_RESET  = 7'd32;

   localparam logic [FIT_W-1:0]  FIT_SCALE    = 14'd10000;
   localparam logic [WORD_W-1:0] FIT_SCALE_X2 = 32'd20000;
   localparam logic [SUM_W-1:0]  SUM_LIMIT    = {SUM_W{1'b1}};

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SELECT = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_CHROM_BITS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POP_COUNT  = 1'd1;

   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] word;
      logic [BITS_W-1:0] bits;
   } fit_req_type;

   typedef struct packed {
      logic             done;
      logic [FIT_W-1:0] fitness;
   } fit_rsp_type;

   typedef struct packed {
      logic              start;
      logic [SUM_W-1:0]  target;
      logic [POPC_W-1:0] count;
   } scan_req_type;

   typedef struct packed {
      logic              done;
      logic [SLOT_W-1:0] slot;
   } scan_rsp_type;

endpackage

`default_nettype wire

FILE: hw/rtl/rws_fitness_ram.sv
`default_nettype none

module rws_fitness_ram #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [ADDR_W-1:0]        wr_addr,
   input  wire logic [rws_pkg::FIT_W-1:0] wr_data,
   input  wire logic                     rd_en,
   input  wire logic [ADDR_W-1:0]        rd_addr,
   output logic      [rws_pkg::FIT_W-1:0] rd_data
);
   import rws_pkg::*;

   logic [FIT_W-1:0] mem [DEPTH];
   logic [FIT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/rws_fitness_unit.sv
`default_nettype none

module rws_fitness_unit (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rws_pkg::fit_req_type fit_req,
   output rws_pkg::fit_rsp_type      fit_rsp
);
   import rws_pkg::*;

   localparam int PROD_W = 2 * WORD_W;
   localparam int REM_W  = PROD_W + 16;
   localparam int STEP_W = $clog2(FIT_W);

   typedef enum logic [2:0] {
      S_IDLE, S_MUL_X, S_MUL_M, S_MUL_LO, S_MUL_HI, S_ADD, S_DIV, S_DONE
   } fit_state_type;

   fit_state_type     state_ff, state_in;
   logic [WORD_W-1:0] x_ff, x_in, m_ff, m_in;
   logic              zero_ff, zero_in;
   logic [PROD_W-1:0] x2_ff, x2_in, m2_ff, m2_in, plo_ff, plo_in, phi_ff, phi_in;
   logic [REM_W-1:0]  rem_ff, rem_in, den_ff, den_in;
   logic [FIT_W-1:0]  quot_ff, quot_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic [BITS_W-1:0] n_eff;
   logic [WORD_W-1:0] mask;
   logic [WORD_W-1:0] mul_a, mul_b;
   logic [PROD_W-1:0] product;
   logic              trial;

   assign n_eff   = (fit_req.bits > CHROM_MAX) ? CHROM_MAX : fit_req.bits;
   assign mask    = ~({WORD_W{1'b1}} << n_eff);
   assign product = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign trial   = rem_ff >= den_ff;

   always_comb begin
      case (state_ff)
         S_MUL_X: begin
            mul_a = x_ff;
            mul_b = x_ff;
         end
         S_MUL_M: begin
            mul_a = m_ff;
            mul_b = m_ff;
         end
         S_MUL_LO: begin
            mul_a = x2_ff[WORD_W-1:0];
            mul_b = FIT_SCALE_X2;
         end
         S_MUL_HI: begin
            mul_a = x2_ff[PROD_W-1:WORD_W];
            mul_b = FIT_SCALE_X2;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      m_in     = m_ff;
      zero_in  = zero_ff;
      x2_in    = x2_ff;
      m2_in    = m2_ff;
      plo_in   = plo_ff;
      phi_in   = phi_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quot_in  = quot_ff;
      step_in  = step_ff;
      case (state_ff)
         S_IDLE: begin
            if (fit_req.start) begin
               x_in     = fit_req.word & mask;
               m_in     = mask;
               zero_in  = fit_req.bits == '0;
               state_in = S_MUL_X;
            end
         end
         S_MUL_X: begin
            x2_in    = product;
            state_in = S_MUL_M;
         end
         S_MUL_M: begin
            m2_in    = product;
            state_in = S_MUL_LO;
         end
         S_MUL_LO: begin
            plo_in   = product;
            state_in = S_MUL_HI;
         end
         S_MUL_HI: begin
            phi_in   = product;
            state_in = S_ADD;
         end
         S_ADD: begin
            // numerator 20000 x^2 + m^2 over denominator 2 m^2
            rem_in   = (REM_W'(phi_ff) << WORD_W) + REM_W'(plo_ff) + REM_W'(m2_ff);
            den_in   = REM_W'(m2_ff) << FIT_W;
            quot_in  = '0;
            step_in  = STEP_W'(FIT_W - 1);
            state_in = S_DIV;
         end
         S_DIV: begin
            if (trial) begin
               rem_in = rem_ff - den_ff;
            end
            den_in  = den_ff >> 1;
            quot_in = {quot_ff[FIT_W-2:0], trial};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      x_ff    <= x_in;
      m_ff    <= m_in;
      zero_ff <= zero_in;
      x2_ff   <= x2_in;
      m2_ff   <= m2_in;
      plo_ff  <= plo_in;
      phi_ff  <= phi_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
      step_ff <= step_in;
   end

   assign fit_rsp.done    = state_ff == S_DONE;
   assign fit_rsp.fitness = zero_ff ? '0 : quot_ff;

   a_fitness_in_range: assert property (@(posedge clock) disable iff (reset)
      fit_rsp.done |-> fit_rsp.fitness <= FIT_SCALE)
      else $error("fitness above full scale");

endmodule

`default_nettype wire

FILE: hw/rtl/rws_scan.sv
`default_nettype none

module rws_scan #(
   parameter int ADDR_W = 6
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire rws_pkg::scan_req_type     scan_req,
   output rws_pkg::scan_rsp_type          scan_rsp,
   output logic                           rd_en,
   output logic      [ADDR_W-1:0]         rd_addr,
   input  wire logic [rws_pkg::FIT_W-1:0] rd_data
);
   import rws_pkg::*;

   localparam int CUM_W = FIT_W + POPC_W;

   logic              busy_ff, busy_in;
   logic [POPC_W-1:0] issue_ff, issue_in;
   logic              pend_ff, pend_in;
   logic [POPC_W-1:0] pend_idx_ff, pend_idx_in;
   logic [CUM_W-1:0]  cum_ff, cum_in;
   logic [SUM_W-1:0]  target_ff, target_in;
   logic [POPC_W-1:0] count_ff, count_in;
   logic              done_ff, done_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;

   logic [CUM_W-1:0]  cum_sum;
   logic              hit, last;

   assign rd_en   = busy_ff && (issue_ff < count_ff);
   assign rd_addr = ADDR_W'(issue_ff);
   assign cum_sum = cum_ff + CUM_W'(rd_data);
   assign hit     = cum_sum >= CUM_W'(target_ff);
   assign last    = pend_idx_ff == (count_ff - 1'b1);

   always_comb begin
      busy_in     = busy_ff;
      issue_in    = issue_ff;
      pend_in     = 1'b0;
      pend_idx_in = pend_idx_ff;
      cum_in      = cum_ff;
      target_in   = target_ff;
      count_in    = count_ff;
      done_in     = 1'b0;
      slot_in     = slot_ff;
      if (scan_req.start) begin
         busy_in   = 1'b1;
         issue_in  = '0;
         cum_in    = '0;
         target_in = scan_req.target;
         count_in  = scan_req.count;
      end else if (busy_ff) begin
         if (rd_en) begin
            issue_in    = issue_ff + 1'b1;
            pend_in     = 1'b1;
            pend_idx_in = issue_ff;
         end
         if (pend_ff) begin
            cum_in = cum_sum;
            // first slot reaching the target, else the last one scanned
            if (hit || last) begin
               done_in = 1'b1;
               slot_in = SLOT_W'(pend_idx_ff);
               busy_in = 1'b0;
               pend_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pend_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         pend_ff <= pend_in;
         done_ff <= done_in;
      end
      issue_ff    <= issue_in;
      pend_idx_ff <= pend_idx_in;
      cum_ff      <= cum_in;
      target_ff   <= target_in;
      count_ff    <= count_in;
      slot_ff     <= slot_in;
   end

   assign scan_rsp.done = done_ff;
   assign scan_rsp.slot = slot_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/roulette_wheel_selection_engine.sv
// Fitness-proportionate selection over a table of up to POP_MAX slots. A load
// beat decodes the chromosome, stores its fitness (0..10000) in the fitness
// RAM and updates the running sum, minimum, maximum and best slot; a load of
// slot 0 restarts those statistics. A select beat walks the fitness RAM from
// slot 0, one entry per cycle through its single read port, and returns the
// first slot whose running total reaches the scaled random fraction, else the
// last slot scanned; with a zero sum it returns the random index, clamped to
// the population, without a walk. Items are handled one at a time: a load uses
// the shared 32x32 multiplier (four products) and the 14-step restoring
// divider. The response register lets the next beat be taken while a result
// waits. Slots read by a select must have been loaded first;
// the table has no reset and needs no clearing after reset.
`default_nettype none

module roulette_wheel_selection_engine #(
   parameter int POP_MAX = rws_pkg::POP_MAX_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [rws_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rws_pkg::CSR_DATA_W-1:0] csr_wr_data,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_opcode,
   input  wire logic [rws_pkg::SLOT_W-1:0]     req_slot,
   input  wire logic [rws_pkg::WORD_W-1:0]     req_chromosome,
   input  wire logic [rws_pkg::FRAC_W-1:0]     req_random_fraction,
   input  wire logic [rws_pkg::SLOT_W-1:0]     req_random_index,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [rws_pkg::FIT_W-1:0]      rsp_fitness_value,
   output logic      [rws_pkg::SLOT_W-1:0]     rsp_selected_slot,
   output logic      [rws_pkg::SUM_W-1:0]      rsp_fitness_total,
   output logic      [rws_pkg::FIT_W-1:0]      rsp_lowest_fitness,
   output logic      [rws_pkg::FIT_W-1:0]      rsp_highest_fitness,
   output logic      [rws_pkg::SLOT_W-1:0]     rsp_best_slot
);
   import rws_pkg::*;

   localparam int IDX_W = $clog2(POP_MAX);

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOAD_GO, ST_LOAD_WAIT, ST_SCAN_GO, ST_SCAN_WAIT, ST_FINISH
   } eng_state_type;

   eng_state_type     state_ff, state_in;
   logic [BITS_W-1:0] chrom_bits_ff, chrom_bits_in;
   logic [POPC_W-1:0] pop_count_ff, pop_count_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [FIT_W-1:0]  min_ff, min_in, max_ff, max_in;
   logic [SLOT_W-1:0] best_ff, best_in;
   logic              op_ff, op_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [SUM_W-1:0]  target_ff, target_in;
   logic [FIT_W-1:0]  res_fit_ff, res_fit_in;
   logic [SLOT_W-1:0] res_sel_ff, res_sel_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [FIT_W-1:0]  rsp_fit_ff, rsp_fit_in;
   logic [SLOT_W-1:0] rsp_sel_ff, rsp_sel_in;
   logic [SUM_W-1:0]  rsp_sum_ff, rsp_sum_in;
   logic [FIT_W-1:0]  rsp_min_ff, rsp_min_in, rsp_max_ff, rsp_max_in;
   logic [SLOT_W-1:0] rsp_best_ff, rsp_best_in;

   fit_req_type  fit_req;
   fit_rsp_type  fit_rsp;
   scan_req_type scan_req;
   scan_rsp_type scan_rsp;

   logic                    ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]        ram_rd_addr;
   logic [FIT_W-1:0]        ram_rd_data;

   logic [POPC_W-1:0]       pop_eff;
   logic [FRAC_W+SUM_W-1:0] target_prod;
   logic [SUM_W:0]          sum_add;
   logic                    out_free;
   logic                    req_take;
   logic                    slot_stored;

   assign pop_eff = (pop_count_ff == '0) ? POPC_W'(1) :
                    (int'(pop_count_ff) > POP_MAX) ? POPC_W'(POP_MAX) : pop_count_ff;
   assign target_prod = (FRAC_W+SUM_W)'(req_random_fraction) * (FRAC_W+SUM_W)'(sum_ff);
   assign sum_add     = {1'b0, sum_ff} + (SUM_W+1)'(res_fit_ff);
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign req_ready   = state_ff == ST_IDLE;
   assign req_take    = req_valid && req_ready;
   assign slot_stored = int'(slot_ff) < POP_MAX;
   assign ram_wr_en   = (state_ff == ST_FINISH) && out_free && (op_ff == OP_LOAD) &&
                        slot_stored;

   assign fit_req.start  = state_ff == ST_LOAD_GO;
   assign fit_req.word   = word_ff;
   assign fit_req.bits   = chrom_bits_ff;
   assign scan_req.start  = state_ff == ST_SCAN_GO;
   assign scan_req.target = target_ff;
   assign scan_req.count  = pop_eff;

   rws_fitness_unit u_fitness (
      .clock   (clock),
      .reset   (reset),
      .fit_req (fit_req),
      .fit_rsp (fit_rsp)
   );

   rws_fitness_ram #(
      .DEPTH  (POP_MAX),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (IDX_W'(slot_ff)),
      .wr_data (res_fit_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   rws_scan #(
      .ADDR_W (IDX_W)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .scan_req (scan_req),
      .scan_rsp (scan_rsp),
      .rd_en    (ram_rd_en),
      .rd_addr  (ram_rd_addr),
      .rd_data  (ram_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      chrom_bits_in = chrom_bits_ff;
      pop_count_in  = pop_count_ff;
      sum_in        = sum_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      best_in       = best_ff;
      op_in         = op_ff;
      slot_in       = slot_ff;
      word_in       = word_ff;
      target_in     = target_ff;
      res_fit_in    = res_fit_ff;
      res_sel_in    = res_sel_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_fit_in    = rsp_fit_ff;
      rsp_sel_in    = rsp_sel_ff;
      rsp_sum_in    = rsp_sum_ff;
      rsp_min_in    = rsp_min_ff;
      rsp_max_in    = rsp_max_ff;
      rsp_best_in   = rsp_best_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_CHROM_BITS: chrom_bits_in = csr_wr_data[BITS_W-1:0];
            CSR_POP_COUNT:  pop_count_in  = csr_wr_data[POPC_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               op_in   = req_opcode;
               slot_in = req_slot;
               word_in = req_chromosome;
               if (req_opcode == OP_LOAD) begin
                  state_in = ST_LOAD_GO;
               end else if (sum_ff == '0) begin
                  res_fit_in = '0;
                  res_sel_in = (POPC_W'(req_random_index) < pop_eff) ? req_random_index :
                               SLOT_W'(pop_eff - 1'b1);
                  state_in   = ST_FINISH;
               end else begin
                  target_in = SUM_W'(target_prod >> RAND_BITS);
                  state_in  = ST_SCAN_GO;
               end
            end
         end
         ST_LOAD_GO: begin
            state_in = ST_LOAD_WAIT;
         end
         ST_LOAD_WAIT: begin
            if (fit_rsp.done) begin
               res_fit_in = fit_rsp.fitness;
               res_sel_in = '0;
               state_in   = ST_FINISH;
            end
         end
         ST_SCAN_GO: begin
            state_in = ST_SCAN_WAIT;
         end
         ST_SCAN_WAIT: begin
            if (scan_rsp.done) begin
               res_fit_in = '0;
               res_sel_in = scan_rsp.slot;
               state_in   = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               if (op_ff == OP_LOAD) begin
                  if (slot_ff == '0) begin
                     sum_in  = SUM_W'(res_fit_ff);
                     min_in  = res_fit_ff;
                     max_in  = res_fit_ff;
                     best_in = '0;
                  end else begin
                     sum_in = sum_add[SUM_W] ? SUM_LIMIT : sum_add[SUM_W-1:0];
                     if (res_fit_ff < min_ff) begin
                        min_in = res_fit_ff;
                     end
                     if (res_fit_ff > max_ff) begin
                        max_in  = res_fit_ff;
                        best_in = slot_ff;
                     end
                  end
               end
               rsp_valid_in = 1'b1;
               rsp_fit_in   = res_fit_ff;
               rsp_sel_in   = res_sel_ff;
               rsp_sum_in   = sum_in;
               rsp_min_in   = min_in;
               rsp_max_in   = max_in;
               rsp_best_in  = best_in;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         chrom_bits_ff <= CHROM_BITS_RESET;
         pop_count_ff  <= POP_COUNT_RESET;
         sum_ff        <= '0;
         min_ff        <= '0;
         max_ff        <= '0;
         best_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         chrom_bits_ff <= chrom_bits_in;
         pop_count_ff  <= pop_count_in;
         sum_ff        <= sum_in;
         min_ff        <= min_in;
         max_ff        <= max_in;
         best_ff       <= best_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff       <= op_in;
      slot_ff     <= slot_in;
      word_ff     <= word_in;
      target_ff   <= target_in;
      res_fit_ff  <= res_fit_in;
      res_sel_ff  <= res_sel_in;
      rsp_fit_ff  <= rsp_fit_in;
      rsp_sel_ff  <= rsp_sel_in;
      rsp_sum_ff  <= rsp_sum_in;
      rsp_min_ff  <= rsp_min_in;
      rsp_max_ff  <= rsp_max_in;
      rsp_best_ff <= rsp_best_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_fitness_value   = rsp_fit_ff;
   assign rsp_selected_slot   = rsp_sel_ff;
   assign rsp_fitness_total   = rsp_sum_ff;
   assign rsp_lowest_fitness  = rsp_min_ff;
   assign rsp_highest_fitness = rsp_max_ff;
   assign rsp_best_slot       = rsp_best_ff;

   a_scan_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      scan_rsp.done |-> state_ff == ST_SCAN_WAIT)
      else $error("scan finished outside a select");

   a_fit_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      fit_rsp.done |-> state_ff == ST_LOAD_WAIT)
      else $error("fitness finished outside a load");

   a_min_below_max: assert property (@(posedge clock) disable iff (reset)
      min_ff <= max_ff)
      else $error("lowest fitness above highest fitness");

   a_sum_covers_max: assert property (@(posedge clock) disable iff (reset)
      sum_ff >= SUM_W'(max_ff))
      else $error("fitness total below highest fitness");

endmodule

`default_nettype wire

FILE: tb/sv/rws_checker.sv
`default_nettype none

module rws_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [rws_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rws_pkg::CSR_DATA_W-1:0] csr_wr_data,
   input  wire logic                           req_valid,
   input  wire logic                           req_ready,
   input  wire logic                           req_opcode,
   input  wire logic [rws_pkg::SLOT_W-1:0]     req_slot,
   input  wire logic [rws_pkg::WORD_W-1:0]     req_chromosome,
   input  wire logic [rws_pkg::FRAC_W-1:0]     req_random_fraction,
   input  wire logic [rws_pkg::SLOT_W-1:0]     req_random_index,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   input  wire logic [rws_pkg::FIT_W-1:0]      rsp_fitness_value,
   input  wire logic [rws_pkg::SLOT_W-1:0]     rsp_selected_slot,
   input  wire logic [rws_pkg::SUM_W-1:0]      rsp_fitness_total,
   input  wire logic [rws_pkg::FIT_W-1:0]      rsp_lowest_fitness,
   input  wire logic [rws_pkg::FIT_W-1:0]      rsp_highest_fitness,
   input  wire logic [rws_pkg::SLOT_W-1:0]     rsp_best_slot,
   output int                                  error_count,
   output int                                  pending_results,
   output int                                  results_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   import rws_pkg::*;

   typedef struct packed {
      logic [FIT_W-1:0]  fitness_value;
      logic [SLOT_W-1:0] selected_slot;
      logic [SUM_W-1:0]  fitness_total;
      logic [FIT_W-1:0]  lowest_fitness;
      logic [FIT_W-1:0]  highest_fitness;
      logic [SLOT_W-1:0] best_slot;
   } wheel_result_type;

   wheel_result_type  awaited_results[$];
   logic [FIT_W-1:0]  fitness_table[POP_MAX_DEFAULT];
   logic [SUM_W-1:0]  running_total;
   logic [FIT_W-1:0]  lowest_seen;
   logic [FIT_W-1:0]  highest_seen;
   logic [SLOT_W-1:0] best_seen;
   logic [BITS_W-1:0] wheel_bits;
   logic [POPC_W-1:0] wheel_pop;

   // round(10000 * x^2 / M^2) with ties upward, done in wide integers
   function automatic logic [FIT_W-1:0] scaled_fitness(logic [WORD_W-1:0] word,
                                                        logic [BITS_W-1:0] bits);
      logic [127:0] span;
      logic [127:0] value;
      logic [127:0] numer;
      logic [127:0] denom;
      int unsigned  n;
      n = 32'((bits > CHROM_MAX) ? CHROM_MAX : bits);
      if (n == 0) return '0;
      span  = (128'd1 << n) - 128'd1;
      value = {96'd0, word} & span;
      numer = 128'(FIT_SCALE_X2) * value * value + span * span;
      denom = 128'd2 * span * span;
      return FIT_W'(numer / denom);
   endfunction

   function automatic wheel_result_type predict_wheel_result(logic op,
                                                             logic [SLOT_W-1:0] slot,
                                                             logic [WORD_W-1:0] word,
                                                             logic [FRAC_W-1:0] frac,
                                                             logic [SLOT_W-1:0] ridx);
      wheel_result_type  res;
      logic [FIT_W-1:0]  fit;
      logic [SUM_W:0]    grown;
      logic [35:0]       target;
      logic [35:0]       cum;
      int unsigned       scan_len;
      res = '0;
      if (op == OP_LOAD) begin
         fit = scaled_fitness(word, wheel_bits);
         res.fitness_value = fit;
         fitness_table[slot] = fit;
         if (slot == 0) begin
            running_total = SUM_W'(fit);
            lowest_seen = fit;
            highest_seen = fit;
            best_seen = '0;
         end else begin
            grown = (SUM_W+1)'(running_total) + (SUM_W+1)'(fit);
            running_total = grown[SUM_W] ? SUM_LIMIT : grown[SUM_W-1:0];
            if (fit < lowest_seen) lowest_seen = fit;
            if (fit > highest_seen) begin
               highest_seen = fit;
               best_seen = slot;
            end
         end
      end else begin
         scan_len = (wheel_pop == '0) ? 1 :
                    (int'(wheel_pop) > POP_MAX_DEFAULT) ? POP_MAX_DEFAULT : int'(wheel_pop);
         if (running_total == 0) begin
            res.selected_slot = (32'(ridx) < scan_len) ? ridx : SLOT_W'(scan_len - 1);
         end else begin
            target = (36'(frac) * 36'(running_total)) >> RAND_BITS;
            cum = '0;
            res.selected_slot = SLOT_W'(scan_len - 1);
            for (int i = 0; i < scan_len; i++) begin
               cum += 36'(fitness_table[i]);
               if (cum >= target) begin
                  res.selected_slot = SLOT_W'(i);
                  break;
               end
            end
         end
      end
      res.fitness_total = running_total;
      res.lowest_fitness = lowest_seen;
      res.highest_fitness = highest_seen;
      res.best_slot = best_seen;
      return res;
   endfunction

   function automatic int field_mismatch(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      wheel_result_type want;
      if (reset) begin
         awaited_results.delete();
         running_total = '0;
         lowest_seen = '0;
         highest_seen = '0;
         best_seen = '0;
         wheel_bits = CHROM_BITS_RESET;
         wheel_pop = POP_COUNT_RESET;
         foreach (fitness_table[i]) fitness_table[i] = '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_CHROM_BITS: wheel_bits = csr_wr_data[BITS_W-1:0];
               CSR_POP_COUNT:  wheel_pop = csr_wr_data[POPC_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $error("response beat with no prediction waiting");
               error_count++;
            end else begin
               want = awaited_results.pop_front();
               results_checked++;
               error_count += field_mismatch("fitness_value", 32'(want.fitness_value),
                                             32'(rsp_fitness_value));
               error_count += field_mismatch("selected_slot", 32'(want.selected_slot),
                                             32'(rsp_selected_slot));
               error_count += field_mismatch("fitness_total", 32'(want.fitness_total),
                                             32'(rsp_fitness_total));
               error_count += field_mismatch("lowest_fitness", 32'(want.lowest_fitness),
                                             32'(rsp_lowest_fitness));
               error_count += field_mismatch("highest_fitness", 32'(want.highest_fitness),
                                             32'(rsp_highest_fitness));
               error_count += field_mismatch("best_slot", 32'(want.best_slot),
                                             32'(rsp_best_slot));
            end
         end
         if (req_valid && req_ready)
            awaited_results.push_back(predict_wheel_result(req_opcode, req_slot,
                                                           req_chromosome,
                                                           req_random_fraction,
                                                           req_random_index));
      end
      pending_results <= awaited_results.size();
   end

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rws_pkg::*;

   localparam int QUIET_LIMIT = 5000;
   localparam int HOLD_CYCLES = 400;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_opcode = OP_LOAD;
   logic [SLOT_W-1:0]     req_slot = '0;
   logic [WORD_W-1:0]     req_chromosome = '0;
   logic [FRAC_W-1:0]     req_random_fraction = '0;
   logic [SLOT_W-1:0]     req_random_index = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [FIT_W-1:0]      rsp_fitness_value;
   logic [SLOT_W-1:0]     rsp_selected_slot;
   logic [SUM_W-1:0]      rsp_fitness_total;
   logic [FIT_W-1:0]      rsp_lowest_fitness;
   logic [FIT_W-1:0]      rsp_highest_fitness;
   logic [SLOT_W-1:0]     rsp_best_slot;

   int   error_count;
   int   pending_results;
   int   results_checked;
   int   send_idle_pct = 35;
   int   recv_stall_pct = 77;
   int   requests_sent = 0;
   int   settings_used = 1;
   int   quiet_cycles = 0;
   int   hold_left = 0;
   logic hold_request = 1'b0;
   logic hold_taken = 1'b0;

   always #1 clock = ~clock;

   roulette_wheel_selection_engine u_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_slot            (req_slot),
      .req_chromosome      (req_chromosome),
      .req_random_fraction (req_random_fraction),
      .req_random_index    (req_random_index),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_fitness_value   (rsp_fitness_value),
      .rsp_selected_slot   (rsp_selected_slot),
      .rsp_fitness_total   (rsp_fitness_total),
      .rsp_lowest_fitness  (rsp_lowest_fitness),
      .rsp_highest_fitness (rsp_highest_fitness),
      .rsp_best_slot       (rsp_best_slot)
   );

   rws_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_slot            (req_slot),
      .req_chromosome      (req_chromosome),
      .req_random_fraction (req_random_fraction),
      .req_random_index    (req_random_index),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_fitness_value   (rsp_fitness_value),
      .rsp_selected_slot   (rsp_selected_slot),
      .rsp_fitness_total   (rsp_fitness_total),
      .rsp_lowest_fitness  (rsp_lowest_fitness),
      .rsp_highest_fitness (rsp_highest_fitness),
      .rsp_best_slot       (rsp_best_slot),
      .error_count         (error_count),
      .pending_results     (pending_results),
      .results_checked     (results_checked)
   );

   // receiver, with one long hold-off so the engine backs up
   always @(posedge clock) begin
      if (hold_request && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("tb_top: FAIL");
      $finish;
   end

   task automatic offer(logic op, logic [SLOT_W-1:0] slot, logic [WORD_W-1:0] word,
                        logic [FRAC_W-1:0] frac, logic [SLOT_W-1:0] ridx);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_slot <= slot;
      req_chromosome <= word;
      req_random_fraction <= frac;
      req_random_index <= ridx;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
   endtask

   task automatic load_slot(logic [SLOT_W-1:0] slot, logic [WORD_W-1:0] word);
      offer(OP_LOAD, slot, word, FRAC_W'($urandom()), SLOT_W'($urandom()));
   endtask

   task automatic spin(logic [FRAC_W-1:0] frac, logic [SLOT_W-1:0] ridx);
      offer(OP_SELECT, SLOT_W'($urandom()), $urandom(), frac, ridx);
   endtask

   function automatic logic [WORD_W-1:0] rand_word();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return $urandom();
   endfunction

   function automatic logic [FRAC_W-1:0] rand_frac();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return FRAC_W'($urandom());
   endfunction

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_wheel(logic [CSR_DATA_W-1:0] bits, logic [CSR_DATA_W-1:0] pop);
      drain();
      write_csr(CSR_CHROM_BITS, bits);
      write_csr(CSR_POP_COUNT, pop);
      settings_used++;
   endtask

   // load slot 0 onwards, then spin the wheel a few times
   task automatic run_generation(int size);
      load_slot('0, rand_word());
      for (int s = 1; s < size; s++) load_slot(SLOT_W'(s), rand_word());
      repeat ($urandom_range(1, 6)) spin(rand_frac(), SLOT_W'($urandom()));
   endtask

   task automatic random_mix(int goal);
      while (requests_sent < goal) begin
         if ($urandom_range(9) < 8) begin
            if ($urandom_range(3) != 0)
               run_generation($urandom_range(1, 8));
            else
               run_generation($urandom_range(1, POP_MAX_DEFAULT));
         end else begin
            repeat ($urandom_range(1, 6))
               offer($urandom_range(1) ? OP_SELECT : OP_LOAD, SLOT_W'($urandom()),
                     rand_word(), rand_frac(), SLOT_W'($urandom()));
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty wheel: random index used, clamped to the population
      spin(16'h8000, 6'd63);
      spin(16'h0000, 6'd0);
      // loads ahead of any slot 0 load keep the minimum at zero
      load_slot(6'd3, 32'hFFFF_FFFF);
      load_slot(6'd5, 32'h0000_0080);
      load_slot(6'd0, 32'h0000_0000);
      spin(16'hFFFF, 6'd17);
      for (int s = 0; s < POP_MAX_DEFAULT; s++) load_slot(SLOT_W'(s), rand_word());
      load_slot(6'd63, 32'hFFFF_FFFF);
      load_slot(6'd1, 32'hFFFF_FF00);
      load_slot(6'd2, 32'h0000_0001);
      load_slot(6'd4, 32'h0000_007F);
      spin(16'h0000, 6'd9);
      spin(16'hFFFF, 6'd9);
      spin(16'h8000, 6'd9);
      load_slot(6'd0, 32'hFFFF_FFFF);
      spin(16'h0001, 6'd40);
      random_mix(260);

      send_idle_pct = 77;
      recv_stall_pct = 35;
      set_wheel(7'd32, 7'd64);
      // saturate the running total, then spin past the table contents
      load_slot(6'd0, 32'hFFFF_FFFF);
      for (int i = 0; i < 120; i++) load_slot(SLOT_W'(1 + i % 63), 32'hFFFF_FFFF);
      spin(16'hFFFF, 6'd0);
      spin(16'h8000, 6'd0);
      spin(rand_frac(), 6'd0);
      random_mix(560);

      send_idle_pct = 0;
      recv_stall_pct = 0;
      set_wheel(7'd0, 7'd0);
      hold_request <= 1'b1;
      random_mix(640);
      set_wheel(7'd1, 7'd1);
      random_mix(700);
      set_wheel(7'h7F, 7'h7F);
      random_mix(770);
      set_wheel(7'h45, 7'd20);
      random_mix(840);
      set_wheel(CSR_DATA_W'($urandom_range(1, 32)), CSR_DATA_W'($urandom_range(1, 64)));
      random_mix(950);

      drain();
      repeat (80) @(posedge clock);
      $display("tb_top: %0d request beats sent, %0d results checked, %0d register settings",
               requests_sent, results_checked, settings_used);
      $display("tb_top: empty wheels, saturated totals, clamped registers, long output stall");
      if (error_count == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
